// ----- sv/dri_pkg.sv -----
`default_nettype none

package dri_pkg;

	// integration step after reset, 2^-16 s units (about 10 ms)
	localparam logic [15:0] STEP_TIME_RST = 16'd655;

	// binary angle landmarks, one full turn = 65536
	localparam logic [15:0] QUARTER_TURN  = 16'd16384;
	localparam logic [15:0] HALF_TURN     = 16'd32768;
	localparam logic [15:0] THREE_QUARTER = 16'd49152;

	// rounding offset for the 2^-40 position product
	localparam logic [65:0] POS_RND = 66'h00_0000_0080_0000_0000;

	// highest-order sine coefficient, (pi/2)^9 / 9! in Q30
	localparam logic [31:0] SIN_C4 = 32'd172272;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SPEED,
		ST_FOLD,
		ST_Z2,
		ST_HMUL,
		ST_HSUB,
		ST_PMUL,
		ST_TRIG,
		ST_POSMUL,
		ST_POSUPD,
		ST_PUB
	} state_t;

	// operand selection for the shared multiplier
	typedef enum logic [2:0] {
		OP_HEAD,
		OP_SPEED,
		OP_MAG,
		OP_HORNER,
		OP_POLY,
		OP_POS
	} mul_op_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic       mul_en;
		mul_op_t    mul_op;
		logic       upd_head;
		logic       save_d;
		logic       fold;
		logic       fold_y;
		logic       save_z2;
		logic       horner_sub;
		logic [1:0] coef_idx;
		logic       save_trig;
		logic       upd_pos;
		logic       pos_y;
		logic       publish;
	} ctrl_t;

	// lower-order odd Taylor coefficients of sin(pi/2 * z), Q30
	function automatic logic [31:0] sin_coef(input logic [1:0] k);
		logic [31:0] c;
		case (k)
			2'd0:    c = 32'd1686629713;
			2'd1:    c = 32'd693598668;
			2'd2:    c = 32'd85569306;
			default: c = 32'd5026995;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/dri_mul.sv -----
`default_nettype none

module dri_mul (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [65:0]      prod_q
);

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dri_seq.sv -----
`default_nettype none

module dri_seq (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     out_free,
	output logic          in_ready,
	output dri_pkg::ctrl_t ctrl
);

	import dri_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] k_q, k_d;
	logic       axis_q, axis_d;

	// state, Horner index and axis registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			axis_q  <= axis_d;
		end
	end

	// next state and controls
	always_comb begin
		ctrl     = '0;
		ctrl.mul_op = OP_HEAD;
		state_d  = state_q;
		k_d      = k_q;
		axis_d   = axis_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_HEAD;
				state_d     = ST_SPEED;
			end
			ST_SPEED: begin
				ctrl.upd_head = 1'b1;
				ctrl.mul_en   = 1'b1;
				ctrl.mul_op   = OP_SPEED;
				state_d       = ST_FOLD;
			end
			ST_FOLD: begin
				// cosine first: x axis
				ctrl.save_d = 1'b1;
				ctrl.fold   = 1'b1;
				ctrl.fold_y = 1'b0;
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_MAG;
				axis_d      = 1'b0;
				state_d     = ST_Z2;
			end
			ST_Z2: begin
				ctrl.save_z2 = 1'b1;
				k_d          = 2'd3;
				state_d      = ST_HMUL;
			end
			ST_HMUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_HORNER;
				state_d     = ST_HSUB;
			end
			ST_HSUB: begin
				ctrl.horner_sub = 1'b1;
				ctrl.coef_idx   = k_q;
				if (k_q == 2'd0) begin
					state_d = ST_PMUL;
				end else begin
					k_d     = k_q - 2'd1;
					state_d = ST_HMUL;
				end
			end
			ST_PMUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_POLY;
				state_d     = ST_TRIG;
			end
			ST_TRIG: begin
				ctrl.save_trig = 1'b1;
				state_d        = ST_POSMUL;
			end
			ST_POSMUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_POS;
				state_d     = ST_POSUPD;
			end
			ST_POSUPD: begin
				ctrl.upd_pos = 1'b1;
				ctrl.pos_y   = axis_q;
				if (!axis_q) begin
					// start the sine pass for y
					ctrl.fold   = 1'b1;
					ctrl.fold_y = 1'b1;
					ctrl.mul_en = 1'b1;
					ctrl.mul_op = OP_MAG;
					axis_d      = 1'b1;
					state_d     = ST_Z2;
				end else begin
					state_d = ST_PUB;
				end
			end
			ST_PUB: begin
				if (out_free) begin
					ctrl.publish = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/dead_reckoning_pose_integrator.sv -----
// A result beat is published once both axis passes of its tick are done; no
// new tick is taken before that, as the single shared 33x33 multiplier does all
// 16 multiply/consume steps: heading, distance, two Horner sines and positions.
// A finished pose waits in the output register while the next tick is taken.
// Reset (arst_n low, asynchronous) zeroes the pose and sets step_time to 655.
`default_nettype none

module dead_reckoning_pose_integrator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [15:0] step_time,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] forward_speed,
	input  wire logic signed [23:0] turn_rate,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed      [31:0] pos_x,
	output logic signed      [31:0] pos_y,
	output logic             [15:0] heading
);

	import dri_pkg::*;

	ctrl_t              ctrl;
	logic               out_free;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	logic        [15:0] step_time_q;
	logic signed [15:0] speed_q;
	logic signed [23:0] rate_q;
	logic        [15:0] heading_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic signed [31:0] d_q;
	logic        [14:0] mag_q;
	logic               neg_q;
	logic        [30:0] z2_q;
	logic        [31:0] p_q;
	logic signed [31:0] trig_q;
	logic               out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic        [15:0] heading_out_q;

	logic        [15:0] ang;
	logic        [15:0] mag_w;
	logic        [14:0] mag_c;
	logic               neg_c;
	logic        [31:0] hsum;
	logic        [31:0] tmag;
	logic        [65:0] rsum;
	logic signed [25:0] pos_inc;
	logic signed [31:0] acc_sel;
	logic signed [32:0] pos_sum;
	logic signed [31:0] pos_sat;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	dri_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	dri_mul u_mul (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// step time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= STEP_TIME_RST;
		end else if (cfg_valid) begin
			step_time_q <= step_time;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			speed_q <= forward_speed;
			rate_q  <= turn_rate;
		end
	end

	// quadrant fold: angle to quarter-turn magnitude and sign
	always_comb begin
		ang   = ctrl.fold_y ? heading_q : heading_q + QUARTER_TURN;
		mag_w = ang;
		neg_c = 1'b0;
		if (ang >= QUARTER_TURN && ang < THREE_QUARTER) begin
			if (ang > HALF_TURN) begin
				mag_w = ang - HALF_TURN;
				neg_c = 1'b1;
			end else begin
				mag_w = HALF_TURN - ang;
			end
		end else if (ang >= THREE_QUARTER) begin
			mag_w = 16'd0 - ang;
			neg_c = 1'b1;
		end
		mag_c = mag_w[14:0];
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_op)
			OP_HEAD: begin
				mul_a = {17'd0, step_time_q};
				mul_b = {{9{rate_q[23]}}, rate_q};
			end
			OP_SPEED: begin
				mul_a = {17'd0, step_time_q};
				mul_b = {{17{speed_q[15]}}, speed_q};
			end
			OP_MAG: begin
				mul_a = {18'd0, mag_c};
				mul_b = {18'd0, mag_c};
			end
			OP_HORNER: begin
				mul_a = {1'b0, p_q};
				mul_b = {2'b00, z2_q};
			end
			OP_POLY: begin
				mul_a = {1'b0, p_q};
				mul_b = {2'b00, mag_q, 16'd0};
			end
			OP_POS: begin
				mul_a = {d_q[31], d_q};
				mul_b = {trig_q[31], trig_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product post-processing
	always_comb begin
		hsum    = prod_q[31:0] + 32'h0000_8000;
		tmag    = prod_q[61:30];
		rsum    = prod_q + POS_RND;
		pos_inc = rsum[65:40];
		acc_sel = ctrl.pos_y ? acc_y_q : acc_x_q;
		pos_sum = {acc_sel[31], acc_sel} + {{7{pos_inc[25]}}, pos_inc};
		// clamp to the 32-bit signed range
		if (pos_sum[32] != pos_sum[31]) begin
			pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
		end else begin
			if (ctrl.upd_head) begin
				heading_q <= heading_q + hsum[31:16];
			end
			if (ctrl.upd_pos) begin
				if (ctrl.pos_y) begin
					acc_y_q <= pos_sat;
				end else begin
					acc_x_q <= pos_sat;
				end
			end
		end
	end

	// working registers of the trig and distance path
	always_ff @(posedge clk) begin
		if (ctrl.save_d) begin
			d_q <= prod_q[31:0];
		end
		if (ctrl.fold) begin
			mag_q <= mag_c;
			neg_q <= neg_c;
		end
		if (ctrl.save_z2) begin
			z2_q <= {prod_q[28:0], 2'b00};
			p_q  <= SIN_C4;
		end else if (ctrl.horner_sub) begin
			p_q <= sin_coef(ctrl.coef_idx) - prod_q[61:30];
		end
		if (ctrl.save_trig) begin
			trig_q <= neg_q ? 32'sd0 - tmag : tmag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.publish) begin
			pos_x_q       <= acc_x_q;
			pos_y_q       <= acc_y_q;
			heading_out_q <= heading_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_out_q;

endmodule

`default_nettype wire

// ----- sv/dri_chk.sv -----
`default_nettype none

module dri_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic        [15:0] heading
);

	// an accepted tick keeps the block busy, with in_ready held low after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again too soon after a beat");

	// a fresh result comes out exactly as the block turns idle
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while the block is still busy");

	// an idle block without input stays idle
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("block left idle without an input beat");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(heading))
		else $error("stalled result beat changed");

endmodule

bind dead_reckoning_pose_integrator dri_chk u_chk (.*);

`default_nettype wire

// ----- tb/dead_reckoning_pose_integrator_tb.sv -----
`timescale 1ns / 1ps

module dead_reckoning_pose_integrator_tb;
	import dri_pkg::STEP_TIME_RST;
	import dri_pkg::QUARTER_TURN;
	import dri_pkg::HALF_TURN;
	import dri_pkg::THREE_QUARTER;

	localparam int     DRAIN_CYCLES = 40;
	localparam int     STALL_LIMIT  = 2000;
	localparam int     PRINT_LIMIT  = 100;
	localparam int     RANDOM_BEATS = 80;
	localparam longint POS_MAX      = 64'sd2147483647;
	localparam longint POS_MIN      = -64'sd2147483648;
	localparam longint POS_HALF_LSB = 64'sd549755813888;	// 2^39, rounding for >>> 40

	// expected pose as it appears on the result port
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] hd;
	} pose_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic        [15:0] step_time;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] forward_speed;
	logic signed [23:0] turn_rate;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic        [15:0] heading;

	// predicted block state
	logic [15:0] step_now;
	logic [15:0] head_now;
	longint      x_now;
	longint      y_now;

	pose_t expected_poses[$];
	pose_t pose_due;
	int    mismatch_count;
	int    pose_count;
	int    quiet_cycles;
	bit    no_idle;

	dead_reckoning_pose_integrator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.step_time     (step_time),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.forward_speed (forward_speed),
		.turn_rate     (turn_rate),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading       (heading)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// odd Taylor terms of sin(pi/2 * z) in Q30, highest order at k = 4
	function automatic longint sine_term(input int k);
		case (k)
			0:       return 64'sd1686629713;
			1:       return 64'sd693598668;
			2:       return 64'sd85569306;
			3:       return 64'sd5026995;
			default: return 64'sd172272;
		endcase
	endfunction

	// Q30 sine of a binary angle: fold to a quarter-turn offset, Horner on |z|
	function automatic longint sine_q30(input logic [15:0] ang);
		longint a;
		longint z;
		longint mag;
		longint zq;
		longint z2;
		longint acc;
		int     k;
		a = longint'(ang);
		if (ang >= QUARTER_TURN && ang < THREE_QUARTER) begin
			z = longint'(HALF_TURN) - a;
		end else if (ang >= THREE_QUARTER) begin
			z = a - 65536;
		end else begin
			z = a;
		end
		mag = (z < 0) ? -z : z;
		zq  = mag << 16;
		z2  = (zq * zq) >> 30;
		acc = sine_term(4);
		for (k = 3; k >= 0; k--) begin
			acc = sine_term(k) - ((acc * z2) >> 30);
		end
		acc = (acc * zq) >> 30;
		return (z < 0) ? -acc : acc;
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > POS_MAX) return POS_MAX;
		if (v < POS_MIN) return POS_MIN;
		return v;
	endfunction

	// one Euler tick: heading first, then x/y along the new heading
	task automatic advance_pose(input logic signed [15:0] spd, input logic signed [23:0] rt);
		longint      turn_prod;
		longint      travel;
		logic [63:0] turn_rnd;
		logic [15:0] cos_ang;
		pose_t       want;
		turn_prod = longint'(step_now) * longint'(rt);
		turn_rnd  = turn_prod + 64'd32768;
		head_now  = head_now + turn_rnd[31:16];
		cos_ang   = head_now + QUARTER_TURN;
		travel    = longint'(step_now) * longint'(spd);
		x_now     = clamp_pos(x_now + ((travel * sine_q30(cos_ang) + POS_HALF_LSB) >>> 40));
		y_now     = clamp_pos(y_now + ((travel * sine_q30(head_now) + POS_HALF_LSB) >>> 40));
		want.x    = x_now[31:0];
		want.y    = y_now[31:0];
		want.hd   = head_now;
		expected_poses.push_back(want);
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [23:0] random_rate();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 24'($urandom);
			4, 5, 6:    return 24'($urandom_range(0, 40000)) - 24'd20000;
			7:          return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			8:          return 24'sd0;
			default:    return 24'($urandom_range(0, 32)) - 24'd16;
		endcase
	endfunction

	function automatic logic signed [15:0] random_speed();
		case ($urandom_range(0, 9))
			7:       return 16'sh7FFF;
			8:       return 16'sh8000;
			9:       return 16'($urandom_range(0, 128)) - 16'd64;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] pose beat %0d %s: got %0d, want %0d", $time, pose_count, what, got,
				want);
	endtask

	// send one tick beat; valid stays high across back-to-back beats
	task automatic send_tick(input logic signed [15:0] spd, input logic signed [23:0] rt);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      = 1'b1;
		forward_speed = spd;
		turn_rate     = rt;
		do @(posedge clk); while (!in_ready);
		advance_pose(spd, rt);
	endtask

	// drop valid and wait for every pending pose
	task automatic settle_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_step_time(input logic [15:0] v);
		settle_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		step_time = v;
		do @(posedge clk); while (!cfg_ready);
		step_now = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one tick at step 16384 turns the heading exactly to the target
	task automatic steer_tick(input logic [15:0] target, input logic signed [15:0] spd);
		logic [15:0] delta;
		int          rt;
		delta = target - head_now;
		if (delta >= HALF_TURN) rt = 4 * (int'(delta) - 65536);
		else rt = 4 * int'(delta);
		send_tick(spd, 24'(rt));
	endtask

	// first ticks run on the step time left by reset
	task automatic test_reset_step();
		send_tick(16'sh7FFF, 24'sd0);
		send_tick(16'sh8000, 24'sd6553600);
	endtask

	task automatic test_field_extremes();
		write_step_time(16'hFFFF);
		send_tick(16'sh7FFF, 24'sh7FFFFF);
		send_tick(16'sh8000, 24'sh800000);
		send_tick(16'sd0, 24'sd0);
		send_tick(16'sh7FFF, 24'sh800000);
		send_tick(16'sh8000, 24'sh7FFFFF);
		send_tick(16'sd1, 24'sd1);
		send_tick(-16'sd1, -24'sd1);
		write_step_time(16'd1);
		send_tick(16'sh7FFF, 24'sh7FFFFF);
		send_tick(16'sh8000, 24'sh800000);
		send_tick(16'sd1, -24'sd1);
	endtask

	// zero step time: pose must not move
	task automatic test_zero_step();
		write_step_time(16'd0);
		send_tick(16'sh7FFF, 24'sh7FFFFF);
		send_tick(16'sh8000, 24'sh800000);
		send_tick(16'sd1234, -24'sd4321);
	endtask

	// sine folding around every quadrant boundary, heading wrap upwards through zero
	task automatic test_heading_fold();
		write_step_time(16'd16384);
		steer_tick(16'd0, 16'sh7FFF);
		steer_tick(16'd1, 16'sh8000);
		steer_tick(16'd16383, 16'sh7FFF);
		steer_tick(16'd16384, 16'sh8000);
		steer_tick(16'd16385, 16'sh7FFF);
		steer_tick(16'd32767, 16'sh8000);
		steer_tick(16'd32768, 16'sh7FFF);
		steer_tick(16'd49151, 16'sh8000);
		steer_tick(16'd49152, 16'sh7FFF);
		steer_tick(16'd49153, 16'sh8000);
		steer_tick(16'd65535, 16'sh7FFF);
		steer_tick(16'd0, 16'sh8000);
	endtask

	task automatic test_random_ticks();
		int          phase;
		logic [15:0] st;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       st = STEP_TIME_RST;
				1:       st = 16'hFFFF;
				2:       st = 16'd1;
				3:       st = 16'($urandom_range(1, 65535));
				default: st = 16'($urandom_range(1, 2000));
			endcase
			write_step_time(st);
			no_idle = (phase == 3);
			repeat (RANDOM_BEATS) send_tick(random_speed(), random_rate());
		end
		no_idle = 1'b0;
	endtask

	// result side back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (no_idle) begin
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				out_ready  = 1'b0;
				stall_left = pick_gap();
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// compare each pose beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_poses.size() == 0) begin
				report_mismatch("arrived with none pending", pos_x, 0);
			end else begin
				pose_due = expected_poses.pop_front();
				if (pos_x !== pose_due.x)
					report_mismatch("pos_x", pos_x, $signed(pose_due.x));
				if (pos_y !== pose_due.y)
					report_mismatch("pos_y", pos_y, $signed(pose_due.y));
				if (heading !== pose_due.hd)
					report_mismatch("heading", heading, pose_due.hd);
			end
			pose_count++;
		end
	end

	// watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("dead_reckoning_pose_integrator verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		step_time      = STEP_TIME_RST;
		in_valid       = 1'b0;
		forward_speed  = '0;
		turn_rate      = '0;
		no_idle        = 1'b0;
		mismatch_count = 0;
		pose_count     = 0;
		quiet_cycles   = 0;
		step_now       = STEP_TIME_RST;
		head_now       = '0;
		x_now          = 0;
		y_now          = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_step();
		test_field_extremes();
		test_zero_step();
		test_heading_fold();
		test_random_ticks();

		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("dead_reckoning_pose_integrator verification clean");
		else
			$display("dead_reckoning_pose_integrator verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/dri_pkg.sv
sv/dri_mul.sv
sv/dri_seq.sv
sv/dead_reckoning_pose_integrator.sv
sv/dri_chk.sv
tb/dead_reckoning_pose_integrator_tb.sv
